[hw/rtl/bts_pkg.sv]
// Package: constants and helpers for the bilinear texture sampler.
`default_nettype none
package bts_pkg;
  localparam int MaxWidth = 256;
  localparam int MaxHeight = 256;
  localparam int ChanBits = 16;
  localparam int XBits = $clog2(MaxWidth);
  localparam int YBits = $clog2(MaxHeight);
  localparam int AddrBits = XBits + YBits;
  localparam int TexelBits = 3 * ChanBits;
  localparam int SizeBits = 9;
  localparam int CoordBits = 18;
  localparam int FracBits = 16;
  localparam logic [CoordBits-1:0] OneQ16 = CoordBits'(65536);
  localparam logic [ChanBits-1:0] RedOne = ChanBits'(16'h0100);
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;
  localparam logic [7:0] REG_WIDTH = 8'd0;
  localparam logic [7:0] REG_HEIGHT = 8'd1;

  typedef logic [ChanBits-1:0] chan_t;
  typedef struct packed {
    chan_t b;
    chan_t g;
    chan_t r;
  } texel_t;

  // Clamp a size register to 1..max and return size-1.
  function automatic logic [SizeBits-1:0] size_m1(input logic [SizeBits-1:0] reg_val,
                                                  input logic [SizeBits-1:0] maxv);
    logic [SizeBits-1:0] s;
    begin
      s = reg_val;
      if (s == '0) s = SizeBits'(1);
      if (s > maxv) s = maxv;
      return s - SizeBits'(1);
    end
  endfunction
endpackage
`default_nettype wire

[hw/rtl/bts_texel_bank.sv]
// Module: one texel memory bank, one write and one registered read port.
`default_nettype none
module bts_texel_bank (
  input  wire logic                           clk,
  input  wire logic                           we,
  input  wire logic [bts_pkg::AddrBits-3:0]   waddr,
  input  wire bts_pkg::texel_t                wdata,
  input  wire logic [bts_pkg::AddrBits-3:0]   raddr,
  output bts_pkg::texel_t                     rdata
);
  bts_pkg::texel_t mem [2**(bts_pkg::AddrBits-2)];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[hw/rtl/bilinear_texture_sampler_unit.sv]
// Top level: bilinear texture sampler with banked texel store.
// Usage:
//   s_axis_* carries one transaction per item: func 0 writes a texel,
//   func 1 samples at (coord_u, coord_v). Only samples give a result on
//   m_axis_*. cfg_* writes tex_width (index 0) and tex_height (index 1); other
//   indexes are ignored. Write only while the block is idle (unchecked).
// Throughput: one item per cycle when not stalled. The texel store is split
//   into four banks by the parity of column and row, so the four neighbours
//   of a sample are always in distinct banks and read in the same cycle.
// Pipeline: the scale multiply registers at the accepting edge; then bank read,
//   neighbour register, horizontal lerp products, vertical lerp products,
//   output register.
// Stall: the pipeline advances only when its output stage is empty or is
//   being taken; s_axis_tready follows that, so a stalled receiver holds
//   the whole pipe and nothing is lost. A write issued right after a sample
//   reaches the banks after that sample's read, so order is preserved.
// Reset: clears all valid bits and sets both sizes to 256. Texel contents
//   stay undefined until written; no clearing pass.
`default_nettype none
module bilinear_texture_sampler_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata, low bit up: texel_x[7:0], texel_y[7:0], texel_red[15:0],
  // texel_green[15:0], texel_blue[15:0], coord_u[17:0], coord_v[17:0], zero pad
  input  wire logic [103:0] s_axis_tdata,
  // tuser: func
  input  wire logic        s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata, low bit up: out_red, out_green, out_blue
  output logic [47:0]      m_axis_tdata,
  // tuser: out_of_range
  output logic             m_axis_tuser,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [8:0]  cfg_data
);
  localparam int AB = bts_pkg::AddrBits;
  localparam int XB = bts_pkg::XBits;
  localparam int YB = bts_pkg::YBits;
  localparam int FB = bts_pkg::FracBits;
  localparam int SB = bts_pkg::SizeBits;
  localparam int CB = bts_pkg::ChanBits;
  localparam int PW = CB + FB + 1;

  logic [SB-1:0] tex_width, tex_height;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      tex_width <= SB'(256);
      tex_height <= SB'(256);
    end else if (cfg_valid) begin
      if (cfg_index == bts_pkg::REG_WIDTH) tex_width <= cfg_data;
      else if (cfg_index == bts_pkg::REG_HEIGHT) tex_height <= cfg_data;
    end
  end

  logic adv;
  logic v1, v2, v3, v4, v5;
  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // Stage 1: decode, range check, scale multiply.
  logic signed [17:0] cu, cv;
  assign cu = s_axis_tdata[81:64];
  assign cv = s_axis_tdata[99:82];
  logic oor_in;
  assign oor_in = cu < 0 || cv < 0 || cu > $signed(bts_pkg::OneQ16)
                  || cv > $signed(bts_pkg::OneQ16);

  logic          s1_func, s1_oor;
  logic [XB-1:0] s1_wx;
  logic [YB-1:0] s1_wy;
  bts_pkg::texel_t s1_wd;
  logic [17+SB-1:0] s1_su, s1_sv;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= s_axis_tvalid;
    if (adv) begin
      s1_func <= s_axis_tuser;
      s1_oor <= oor_in;
      s1_wx <= s_axis_tdata[XB-1:0];
      s1_wy <= s_axis_tdata[8+YB-1:8];
      s1_wd <= s_axis_tdata[63:16];
      s1_su <= cu[16:0] * bts_pkg::size_m1(tex_width, SB'(bts_pkg::MaxWidth));
      s1_sv <= cv[16:0] * bts_pkg::size_m1(tex_height, SB'(bts_pkg::MaxHeight));
    end
  end

  // Stage 2: neighbour coordinates; bank writes issue from here.
  logic [XB:0] lu, hu;
  logic [YB:0] lv, hv;
  logic [FB-1:0] tu, tv;
  assign tu = s1_su[FB-1:0];
  assign tv = s1_sv[FB-1:0];
  assign lu = (XB+1)'(s1_su[17+SB-1:FB]);
  assign lv = (YB+1)'(s1_sv[17+SB-1:FB]);
  assign hu = lu + (XB+1)'(tu != '0);
  assign hv = lv + (YB+1)'(tv != '0);

  logic [XB-1:0] x_lo, x_hi;
  logic [YB-1:0] y_lo, y_hi;
  assign x_lo = lu[XB-1:0];
  assign x_hi = hu[XB-1:0];
  assign y_lo = lv[YB-1:0];
  assign y_hi = hv[YB-1:0];

  // Per bank (px,py) the even/odd column and row of the 2x2 neighbourhood.
  logic [XB-1:0] col_e, col_o;
  logic [YB-1:0] row_e, row_o;
  assign col_e = x_lo[0] ? x_hi : x_lo;
  assign col_o = x_lo[0] ? x_lo : x_hi;
  assign row_e = y_lo[0] ? y_hi : y_lo;
  assign row_o = y_lo[0] ? y_lo : y_hi;

  logic [AB-3:0] raddr [4];
  logic          we    [4];
  logic [AB-3:0] waddr;
  assign waddr = {s1_wy[YB-1:1], s1_wx[XB-1:1]};
  always_comb begin
    raddr[0] = {row_e[YB-1:1], col_e[XB-1:1]};
    raddr[1] = {row_e[YB-1:1], col_o[XB-1:1]};
    raddr[2] = {row_o[YB-1:1], col_e[XB-1:1]};
    raddr[3] = {row_o[YB-1:1], col_o[XB-1:1]};
    for (int b = 0; b < 4; b++)
      we[b] = adv && v1 && s1_func == bts_pkg::FUNC_WRITE
              && s1_wx[0] == b[0] && s1_wy[0] == b[1];
  end

  bts_pkg::texel_t rd [4];
  bts_pkg::texel_t rd_hold [4];
  logic hold_ok;
  for (genvar g = 0; g < 4; g++) begin : g_bank
    bts_texel_bank u_bank (
      .clk(clk), .we(we[g]), .waddr(waddr), .wdata(s1_wd),
      .raddr(raddr[g]), .rdata(rd[g])
    );
  end

  logic s2_smp, s2_oor, s2_xo, s2_yo;
  logic [FB-1:0] s2_tu, s2_tv;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1 && s1_func == bts_pkg::FUNC_SAMPLE;
    if (adv) begin
      s2_oor <= s1_oor;
      s2_tu <= tu;
      s2_tv <= tv;
      s2_xo <= x_lo[0];
      s2_yo <= y_lo[0];
    end
  end
  assign s2_smp = v2;

  // Bank read data is valid for one cycle after the read; keep it on stall.
  always_ff @(posedge clk) begin
    if (rst) hold_ok <= 1'b0;
    else hold_ok <= !adv;
    if (!hold_ok) rd_hold <= rd;
  end
  bts_pkg::texel_t q [4];
  always_comb begin
    for (int b = 0; b < 4; b++) q[b] = hold_ok ? rd_hold[b] : rd[b];
  end

  // High neighbour bank parity; with a zero weight the high neighbour is
  // the low texel itself, so take it from the low bank.
  logic s2_hx, s2_hy;
  assign s2_hx = s2_xo ^ (s2_tu != '0);
  assign s2_hy = s2_yo ^ (s2_tv != '0);

  // Stage 3: register neighbours in order 00,10,01,11.
  bts_pkg::texel_t s3_t [4];
  logic s3_oor;
  logic [FB-1:0] s3_tu, s3_tv;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (adv) v3 <= s2_smp;
    if (adv) begin
      s3_oor <= s2_oor;
      s3_tu <= s2_tu;
      s3_tv <= s2_tv;
      s3_t[0] <= q[{s2_yo, s2_xo}];
      s3_t[1] <= q[{s2_yo, s2_hx}];
      s3_t[2] <= q[{s2_hy, s2_xo}];
      s3_t[3] <= q[{s2_hy, s2_hx}];
    end
  end

  // Stage 4: horizontal lerps.
  logic [CB-1:0] s4_top [3], s4_bot [3];
  logic s4_oor;
  logic [FB-1:0] s4_tv;
  logic [FB:0] wu_lo, wu_hi;
  assign wu_hi = {1'b0, s3_tu};
  assign wu_lo = (FB+1)'(1 << FB) - wu_hi;
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (adv) v4 <= v3;
    if (adv) begin
      s4_oor <= s3_oor;
      s4_tv <= s3_tv;
      for (int c = 0; c < 3; c++) begin
        s4_top[c] <= CB'((PW'(s3_t[0][c*CB +: CB]) * PW'(wu_lo)
                          + PW'(s3_t[1][c*CB +: CB]) * PW'(wu_hi)) >> FB);
        s4_bot[c] <= CB'((PW'(s3_t[2][c*CB +: CB]) * PW'(wu_lo)
                          + PW'(s3_t[3][c*CB +: CB]) * PW'(wu_hi)) >> FB);
      end
    end
  end

  // Stage 5: vertical lerp.
  logic [CB-1:0] s5_c [3];
  logic s5_oor;
  logic [FB:0] wv_lo, wv_hi;
  assign wv_hi = {1'b0, s4_tv};
  assign wv_lo = (FB+1)'(1 << FB) - wv_hi;
  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (adv) v5 <= v4;
    if (adv) begin
      s5_oor <= s4_oor;
      for (int c = 0; c < 3; c++)
        s5_c[c] <= CB'((PW'(s4_top[c]) * PW'(wv_lo) + PW'(s4_bot[c]) * PW'(wv_hi)) >> FB);
    end
  end

  // Output register; out-of-range gives plain red.
  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (adv) m_axis_tvalid <= v5;
    if (adv) begin
      m_axis_tuser <= s5_oor;
      if (s5_oor) m_axis_tdata <= {CB'(0), CB'(0), bts_pkg::RedOne};
      else m_axis_tdata <= {s5_c[2], s5_c[1], s5_c[0]};
    end
  end
endmodule
`default_nettype wire
